// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("same-cycle implication violated");

`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("next-cycle implication violated");

`else

`define ASSERT_IMPLY(label, clk, rst_n, pre, post)

`define ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

// ===== hw/rtl/nau_pkg.sv =====
`default_nettype none

package nau_pkg;

  localparam int DATA_W         = 16;
  localparam int FRAC_BITS      = 12;
  localparam int ONE            = 1 << FRAC_BITS;
  localparam int TABLE_SEGMENTS = 64;
  localparam int SEG_BITS       = $clog2(TABLE_SEGMENTS);
  localparam int TAB_IDX_W      = $clog2(TABLE_SEGMENTS + 1);

  localparam int EXP_W  = 31;
  localparam int LOG2_W = 31;
  localparam int Y_W    = DATA_W + LOG2_W;
  localparam int EXP_SH = FRAC_BITS + 30;
  localparam int Q_W    = Y_W - EXP_SH;
  localparam int T_W    = 20;
  localparam int IP_W   = EXP_W + T_W;

  localparam int DIV_STEPS = FRAC_BITS + 1;
  localparam int DIV_D_W   = 32;
  localparam int DIV_N_W   = EXP_SH + 1;

  localparam logic [LOG2_W-1:0] LOG2E_Q30 = 31'd1549082005;
  localparam longint unsigned   LN2_Q30   = 64'd744261118;

  typedef enum logic [2:0] {
    MODE_SIGMOID     = 3'd0,
    MODE_SIG_DERIV   = 3'd1,
    MODE_LEAKY       = 3'd2,
    MODE_LEAKY_DERIV = 3'd3,
    MODE_ELU         = 3'd4,
    MODE_ELU_DERIV   = 3'd5
  } mode_t;

  typedef enum logic [0:0] {
    CFG_MODE  = 1'b0,
    CFG_SLOPE = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [DATA_W-1:0] res;
    logic              sat;
  } word_t;

  typedef struct packed {
    logic  last;
    logic  neg;
    word_t w;
  } tag_t;

  // 2^(-k/segments) in q30, truncated taylor series of exp(-r)
  function automatic logic [EXP_W-1:0] pow2_q30(input int k);
    longint unsigned r;
    longint unsigned term;
    longint unsigned sum;
    r    = (longint'(k) * LN2_Q30 + TABLE_SEGMENTS / 2) / TABLE_SEGMENTS;
    term = 64'd1 << 30;
    sum  = term;
    term = ((term * r) >> 30) / 64'd1;  sum = sum - term;
    term = ((term * r) >> 30) / 64'd2;  sum = sum + term;
    term = ((term * r) >> 30) / 64'd3;  sum = sum - term;
    term = ((term * r) >> 30) / 64'd4;  sum = sum + term;
    term = ((term * r) >> 30) / 64'd5;  sum = sum - term;
    term = ((term * r) >> 30) / 64'd6;  sum = sum + term;
    term = ((term * r) >> 30) / 64'd7;  sum = sum - term;
    term = ((term * r) >> 30) / 64'd8;  sum = sum + term;
    term = ((term * r) >> 30) / 64'd9;  sum = sum - term;
    term = ((term * r) >> 30) / 64'd10; sum = sum + term;
    term = ((term * r) >> 30) / 64'd11; sum = sum - term;
    term = ((term * r) >> 30) / 64'd12; sum = sum + term;
    term = ((term * r) >> 30) / 64'd13; sum = sum - term;
    term = ((term * r) >> 30) / 64'd14; sum = sum + term;
    term = ((term * r) >> 30) / 64'd15; sum = sum - term;
    term = ((term * r) >> 30) / 64'd16; sum = sum + term;
    return (longint'(sum) > 0) ? EXP_W'(sum) : '0;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/nau_div.sv =====
`default_nettype none

// pipelined restoring divider, one quotient bit per stage
module nau_div (
  input  logic                             clk,
  input  logic [nau_pkg::DIV_STEPS-1:0]    en,
  input  logic [nau_pkg::DIV_D_W-1:0]      d_in,
  input  logic [nau_pkg::DIV_D_W-1:0]      p_in,
  input  logic [nau_pkg::DIV_STEPS-1:0]    lo_in,
  output logic [nau_pkg::DIV_STEPS-1:0]    q_out
);

  localparam int STEPS = nau_pkg::DIV_STEPS;
  localparam int D_W   = nau_pkg::DIV_D_W;

  logic [D_W-1:0]   p_r  [STEPS-1];
  logic [D_W-1:0]   d_r  [STEPS-1];
  logic [STEPS-1:0] lo_r [STEPS-1];
  logic [STEPS-1:0] q_r  [STEPS];

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    logic [D_W-1:0]   p_prev;
    logic [D_W-1:0]   d_prev;
    logic [STEPS-1:0] lo_prev;
    logic [STEPS-1:0] q_prev;
    logic [D_W:0]     pw;
    logic             ge;
    logic [STEPS-1:0] q_nxt;

    if (j == 0) begin : g_first
      assign p_prev  = p_in;
      assign d_prev  = d_in;
      assign lo_prev = lo_in;
      assign q_prev  = '0;
    end else begin : g_next
      assign p_prev  = p_r[j-1];
      assign d_prev  = d_r[j-1];
      assign lo_prev = lo_r[j-1];
      assign q_prev  = q_r[j-1];
    end

    always_comb begin
      pw    = {p_prev, lo_prev[STEPS-1]};
      ge    = (pw >= {1'b0, d_prev});
      q_nxt = {q_prev[STEPS-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        q_r[j] <= q_nxt;
      end
    end

    if (j < STEPS - 1) begin : g_carry
      logic [D_W-1:0]   p_nxt;
      logic [STEPS-1:0] lo_nxt;

      always_comb begin
        p_nxt  = ge ? D_W'(pw - {1'b0, d_prev}) : D_W'(pw);
        lo_nxt = lo_prev << 1;
      end

      always_ff @(posedge clk) begin
        if (en[j]) begin
          p_r[j]  <= p_nxt;
          d_r[j]  <= d_prev;
          lo_r[j] <= lo_nxt;
        end
      end
    end
  end

  assign q_out = q_r[STEPS-1];

endmodule

`default_nettype wire

// ===== hw/rtl/neural_activation_unit_top.sv =====
`default_nettype none

// channel   dir  handshake            payload
// in        in   in_valid/in_stall    in_sample[15:0], in_last
// out       out  out_valid/out_stall  out_result[15:0], out_last_out, out_saturated
// cfg       in   cfg_we               cfg_index[0:0], cfg_data[15:0]
//
// one word per cycle sustained while out_stall is low; the 13-stage divider sits
// behind the exp multiply, table, interpolation, shift and divider setup stages
// a stage moves whenever the next one is empty or moving, so bubbles collapse
// and input is taken while a finished word waits on out_stall
// reset clears the valid bits and the mode and slope registers

`include "assert_macros.svh"

module neural_activation_unit_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [nau_pkg::DATA_W-1:0] in_sample,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [nau_pkg::DATA_W-1:0] out_result,
  output logic                              out_last_out,
  output logic                              out_saturated,
  input  logic                              cfg_we,
  input  logic [0:0]                        cfg_index,
  input  logic [nau_pkg::DATA_W-1:0]        cfg_data
);

  localparam int DATA_W    = nau_pkg::DATA_W;
  localparam int FRAC_BITS = nau_pkg::FRAC_BITS;
  localparam int EXP_W     = nau_pkg::EXP_W;
  localparam int Y_W       = nau_pkg::Y_W;
  localparam int EXP_SH    = nau_pkg::EXP_SH;
  localparam int Q_W       = nau_pkg::Q_W;
  localparam int T_W       = nau_pkg::T_W;
  localparam int IP_W      = nau_pkg::IP_W;
  localparam int SEG_BITS  = nau_pkg::SEG_BITS;
  localparam int IDX_W     = nau_pkg::TAB_IDX_W;
  localparam int SEGS      = nau_pkg::TABLE_SEGMENTS;
  localparam int STEPS     = nau_pkg::DIV_STEPS;
  localparam int D_W       = nau_pkg::DIV_D_W;
  localparam int N_W       = nau_pkg::DIV_N_W;
  localparam int E_SH      = 30 - FRAC_BITS;

  localparam int ST_MUL  = 0;
  localparam int ST_TAB  = 1;
  localparam int ST_INT  = 2;
  localparam int ST_SHF  = 3;
  localparam int ST_DIN  = 4;
  localparam int ST_DIV0 = 5;
  localparam int ST_ELU  = ST_DIV0 + 1;
  localparam int ST_OUT  = ST_DIV0 + STEPS;
  localparam int NS      = ST_OUT + 1;

  localparam logic signed [33:0] SAT_MAX = 34'sd32767;
  localparam logic signed [33:0] SAT_MIN = -34'sd32768;

  function automatic nau_pkg::word_t sat16(input logic signed [33:0] v);
    nau_pkg::word_t w;
    if (v > SAT_MAX) begin
      w.res = 16'h7fff;
      w.sat = 1'b1;
    end else if (v < SAT_MIN) begin
      w.res = 16'h8000;
      w.sat = 1'b1;
    end else begin
      w.res = v[DATA_W-1:0];
      w.sat = 1'b0;
    end
    return w;
  endfunction

  function automatic nau_pkg::word_t rnd_sat(input logic signed [33:0] p);
    logic signed [33:0] h;
    h = p + 34'(nau_pkg::ONE / 2);
    return sat16(h >>> FRAC_BITS);
  endfunction

  // config
  logic [2:0]               mode_r;
  logic signed [DATA_W-1:0] slope_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 3'd0;
      slope_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        nau_pkg::CFG_MODE:  mode_r  <= cfg_data[2:0];
        nau_pkg::CFG_SLOPE: slope_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage control
  logic [NS-1:0]   v_r;
  logic [NS-1:0]   v_nxt;
  logic [NS-1:0]   en;
  nau_pkg::tag_t   tag_r   [NS];
  nau_pkg::tag_t   tag_nxt [NS];

  always_comb begin
    en[NS-1] = !v_r[NS-1] || !out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt = v_r;
    if (en[0]) begin
      v_nxt[0] = in_valid;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall = !en[0];

  // pow2 table
  logic [EXP_W-1:0] pow2_tab [SEGS+1];

  for (genvar g = 0; g <= SEGS; g++) begin : g_tab
    assign pow2_tab[g] = nau_pkg::pow2_q30(g);
  end

  // multiply stage
  logic [DATA_W-1:0]        m_abs;
  logic signed [16:0]       om;
  logic signed [32:0]       prod_dd_nxt;
  logic signed [31:0]       prod_lr_nxt;
  logic [Y_W-1:0]           y_nxt;
  logic signed [DATA_W-1:0] x_r;
  logic signed [32:0]       prod_dd_r;
  logic signed [31:0]       prod_lr_r;
  logic [Y_W-1:0]           y_r;

  always_comb begin
    m_abs       = in_sample[DATA_W-1] ? DATA_W'(-in_sample) : DATA_W'(in_sample);
    om          = 17'(nau_pkg::ONE) - 17'(in_sample);
    prod_dd_nxt = 33'(in_sample) * 33'(om);
    prod_lr_nxt = 32'(slope_r) * 32'(in_sample);
    y_nxt       = Y_W'(m_abs) * Y_W'(nau_pkg::LOG2E_Q30);
  end

  // table stage
  logic [IDX_W-1:0] idx_a;
  logic [IDX_W-1:0] idx_b;
  logic [EXP_W-1:0] ta;
  logic [EXP_W-1:0] tb;
  logic [EXP_W-1:0] diff_nxt;
  logic [EXP_W-1:0] a1_r;
  logic [EXP_W-1:0] diff_r;
  logic [T_W-1:0]   t_r;
  logic [Q_W-1:0]   q1_r;

  always_comb begin
    idx_a    = IDX_W'(y_r[EXP_SH-1 -: SEG_BITS]);
    idx_b    = idx_a + IDX_W'(1);
    ta       = pow2_tab[idx_a];
    tb       = pow2_tab[idx_b];
    diff_nxt = (ta >= tb) ? (ta - tb) : '0;
  end

  // interpolation and shift stages
  logic [IP_W-1:0]  ip_nxt;
  logic [IP_W-1:0]  ip_r;
  logic [EXP_W-1:0] a2_r;
  logic [Q_W-1:0]   q2_r;
  logic [EXP_W-1:0] v_interp;
  logic [EXP_W-1:0] e30_nxt;
  logic [EXP_W-1:0] e30_r;

  always_comb begin
    ip_nxt   = IP_W'(diff_r) * IP_W'(t_r);
    v_interp = a2_r - EXP_W'(ip_r >> T_W);
    e30_nxt  = (32'(q2_r) >= 32'd31) ? '0 : (v_interp >> q2_r);
  end

  // divider setup and elu scale
  logic [EXP_W:0]           e_rnd;
  logic signed [DATA_W-1:0] em_nxt;
  logic [D_W-1:0]           d_nxt;
  logic [N_W-1:0]           n_nxt;
  logic signed [DATA_W-1:0] em_r;
  logic [D_W-1:0]           d_r;
  logic [D_W-1:0]           p0_r;
  logic [STEPS-1:0]         lo_r;
  logic signed [31:0]       elu_p_nxt;
  logic signed [31:0]       elu_p_r;
  logic [STEPS-1:0]         div_q;

  always_comb begin
    e_rnd     = (EXP_W + 1)'(e30_r) + ((EXP_W + 1)'(1) << (E_SH - 1));
    em_nxt    = DATA_W'(e_rnd >> E_SH) - DATA_W'(nau_pkg::ONE);
    d_nxt     = D_W'(e30_r) + (D_W'(1) << 30);
    n_nxt     = (N_W'(1) << EXP_SH) + N_W'(d_nxt >> 1);
    elu_p_nxt = 32'(slope_r) * 32'(em_r);
  end

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      x_r       <= in_sample;
      prod_dd_r <= prod_dd_nxt;
      prod_lr_r <= prod_lr_nxt;
      y_r       <= y_nxt;
    end
    if (en[ST_TAB]) begin
      a1_r   <= ta;
      diff_r <= diff_nxt;
      t_r    <= y_r[EXP_SH-1-SEG_BITS -: T_W];
      q1_r   <= y_r[Y_W-1:EXP_SH];
    end
    if (en[ST_INT]) begin
      ip_r <= ip_nxt;
      a2_r <= a1_r;
      q2_r <= q1_r;
    end
    if (en[ST_SHF]) begin
      e30_r <= e30_nxt;
    end
    if (en[ST_DIN]) begin
      em_r <= em_nxt;
      d_r  <= d_nxt;
      p0_r <= D_W'(n_nxt >> STEPS);
      lo_r <= n_nxt[STEPS-1:0];
    end
    if (en[ST_DIV0]) begin
      elu_p_r <= elu_p_nxt;
    end
  end

  nau_div u_div (
    .clk   (clk),
    .en    (en[ST_OUT-1:ST_DIV0]),
    .d_in  (d_r),
    .p_in  (p0_r),
    .lo_in (lo_r),
    .q_out (div_q)
  );

  // per-word tag with results of short modes, negative elu at ST_ELU, sigmoid at ST_OUT
  always_comb begin
    tag_nxt[0] = '{last: in_last, neg: in_sample[DATA_W-1], w: '{res: '0, sat: 1'b0}};
    for (int k = 1; k < NS; k++) begin
      tag_nxt[k] = tag_r[k-1];
    end

    case (mode_r)
      nau_pkg::MODE_SIGMOID: begin
        tag_nxt[ST_TAB].w = '{res: '0, sat: 1'b0};
      end
      nau_pkg::MODE_SIG_DERIV: begin
        tag_nxt[ST_TAB].w = rnd_sat(34'(prod_dd_r));
      end
      nau_pkg::MODE_LEAKY: begin
        tag_nxt[ST_TAB].w = tag_r[ST_MUL].neg ? rnd_sat(34'(prod_lr_r))
                                              : '{res: x_r, sat: 1'b0};
      end
      nau_pkg::MODE_LEAKY_DERIV: begin
        tag_nxt[ST_TAB].w = tag_r[ST_MUL].neg ? '{res: slope_r, sat: 1'b0}
                                              : '{res: DATA_W'(nau_pkg::ONE), sat: 1'b0};
      end
      nau_pkg::MODE_ELU: begin
        tag_nxt[ST_TAB].w = tag_r[ST_MUL].neg ? '{res: '0, sat: 1'b0}
                                              : '{res: x_r, sat: 1'b0};
      end
      nau_pkg::MODE_ELU_DERIV: begin
        tag_nxt[ST_TAB].w = tag_r[ST_MUL].neg ? sat16(34'(x_r) + 34'(slope_r))
                                              : '{res: DATA_W'(nau_pkg::ONE), sat: 1'b0};
      end
      default: begin
        tag_nxt[ST_TAB].w = '{res: '0, sat: 1'b0};
      end
    endcase

    if (mode_r == nau_pkg::MODE_ELU && tag_r[ST_ELU-1].neg) begin
      tag_nxt[ST_ELU].w = rnd_sat(34'(elu_p_r));
    end

    if (mode_r == nau_pkg::MODE_SIGMOID) begin
      tag_nxt[ST_OUT].w.res = tag_r[ST_OUT-1].neg
                              ? DATA_W'(nau_pkg::ONE) - DATA_W'(div_q)
                              : DATA_W'(div_q);
      tag_nxt[ST_OUT].w.sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        tag_r[k] <= tag_nxt[k];
      end
    end
  end

  assign out_valid     = v_r[ST_OUT];
  assign out_result    = tag_r[ST_OUT].w.res;
  assign out_last_out  = tag_r[ST_OUT].last;
  assign out_saturated = tag_r[ST_OUT].w.sat;

  `ASSERT_IMPLY(a_exp_bound, clk, rst_n, v_r[ST_SHF], e30_r <= (EXP_W'(1) << 30))

  `ASSERT_IMPLY(a_div_range, clk, rst_n, v_r[ST_OUT-1], (div_q >= STEPS'(nau_pkg::ONE / 2)) && (div_q <= STEPS'(nau_pkg::ONE)))

  `ASSERT_NEXT(a_sigmoid_out, clk, rst_n, en[ST_OUT] && v_r[ST_OUT-1] && (mode_r == nau_pkg::MODE_SIGMOID), !out_saturated && (out_result >= 16'sd0) && (out_result <= 16'sd4096))

endmodule

`default_nettype wire
